// ----- rtl/bqc_pkg.sv -----
// Shared types, constants and helpers for the cascaded biquad IIR filter.
// No dependencies; used by bqc_hist_mem and biquad_cascade_iir_q13.
package bqc_pkg;

  localparam int NUM_SECTIONS = 4;
  localparam int SEC_W        = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int ACC_W        = 32;
  localparam int FRAC_BITS    = 13;
  localparam int SHIFT_W      = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FF0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTS = 3'd5;

  // product taps of one section
  localparam logic [2:0] TAP_B0 = 3'd0;
  localparam logic [2:0] TAP_B1 = 3'd1;
  localparam logic [2:0] TAP_B2 = 3'd2;
  localparam logic [2:0] TAP_A1 = 3'd3;
  localparam logic [2:0] TAP_A2 = 3'd4;

  // one history row per section
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_row_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [SEC_W-1:0] addr;
    hist_row_t        wdata;
  } hist_port_t;

  function automatic logic signed [COEF_W-1:0] pick16(input logic [CFG_DATA_W-1:0] w,
                                                      input logic [1:0] f);
    return w[COEF_W*f +: COEF_W];
  endfunction

endpackage

// ----- rtl/biquad_cascade_iir_q13.sv -----
// Cascaded biquad IIR filter (direct form I, Q13), top level.
// Takes a new sample only while idle, after the previous result is loaded into the output register;
// each section runs on one shared 16x16 multiply-accumulate (history read, five products,
// add, write back).
// Reset clears control state, coefficients, shifts and all section history.
// Depends on bqc_pkg and bqc_hist_mem.
module biquad_cascade_iir_q13 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_in
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  output logic        m_tlast,   // out_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bqc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bqc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                 state;
  logic [CFG_DATA_W-1:0]      ff_word [3];
  logic [CFG_DATA_W-1:0]      fb_word [2];
  logic [SHIFT_W*(NUM_SECTIONS+1)-1:0] shifts;

  logic [SEC_W-1:0]           sec;
  logic [2:0]                 tap;
  logic signed [SAMPLE_W-1:0] cur;
  logic                       last;
  logic signed [ACC_W-1:0]    prod;
  logic                       prod_sub;
  logic                       prod_valid;
  logic signed [ACC_W-1:0]    acc;

  logic                       out_valid;
  logic [SAMPLE_W-1:0]        out_data;
  logic                       out_last;

  hist_port_t                 hport;
  hist_row_t                  hrow;

  logic signed [SAMPLE_W-1:0] op_x;
  logic signed [COEF_W-1:0]   op_c;
  logic [3:0]                 ff_idx;
  logic [2:0]                 fb_idx;
  logic signed [SAMPLE_W-1:0] sec_y;
  logic [SHIFT_W-1:0]         sec_shift;
  logic signed [SAMPLE_W-1:0] in_shifted;
  logic signed [ACC_W-1:0]    acc_next;
  logic                       sec_is_last;

  bqc_hist_mem u_hist (
    .clk   (clk),
    .rst   (rst),
    .port  (hport),
    .rdata (hrow)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign m_tlast   = out_last;

  assign in_shifted  = $signed(s_tdata) >>> shifts[SHIFT_W-1:0];
  assign sec_y       = acc[FRAC_BITS +: SAMPLE_W];
  assign sec_shift   = shifts[SHIFT_W*(32'(sec)+1) +: SHIFT_W];
  assign sec_is_last = (32'(sec) == NUM_SECTIONS - 1);

  // operand select for the shared multiplier
  always_comb begin
    ff_idx = 4'(3 * 32'(sec)) + 4'(tap);
    fb_idx = 3'(2 * 32'(sec)) + ((tap == TAP_A2) ? 3'd1 : 3'd0);
    unique case (tap)
      TAP_B0:  op_x = cur;
      TAP_B1:  op_x = hrow.x1;
      TAP_B2:  op_x = hrow.x2;
      TAP_A1:  op_x = hrow.y1;
      default: op_x = hrow.y2;
    endcase
    if (tap == TAP_A1 || tap == TAP_A2) begin
      op_c = pick16(fb_word[fb_idx[2]], fb_idx[1:0]);
    end else begin
      op_c = pick16(ff_word[ff_idx[3:2]], ff_idx[1:0]);
    end
  end

  always_comb begin
    acc_next = acc;
    if (prod_valid) begin
      acc_next = prod_sub ? acc - prod : acc + prod;
    end
  end

  // history port: read at section start, write back after the sum
  always_comb begin
    hport.rd_en    = (state == ST_READ);
    hport.wr_en    = (state == ST_WB);
    hport.addr     = sec;
    hport.wdata.x1 = cur;
    hport.wdata.x2 = hrow.x1;
    hport.wdata.y1 = sec_y;
    hport.wdata.y2 = hrow.y1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_word[0] <= '0;
      ff_word[1] <= '0;
      ff_word[2] <= '0;
      fb_word[0] <= '0;
      fb_word[1] <= '0;
      shifts     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FF0:    ff_word[0] <= cfg_data;
        REG_FF1:    ff_word[1] <= cfg_data;
        REG_FF2:    ff_word[2] <= cfg_data;
        REG_FB0:    fb_word[0] <= cfg_data;
        REG_FB1:    fb_word[1] <= cfg_data;
        REG_SHIFTS: shifts     <= cfg_data[SHIFT_W*(NUM_SECTIONS+1)-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sec        <= '0;
      tap        <= TAP_B0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop the beat once taken, unless a new one loads this cycle
      if (out_valid && m_tready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur   <= in_shifted;
            last  <= s_tlast;
            sec   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          acc   <= '0;
          tap   <= TAP_B0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          prod       <= op_x * op_c;
          prod_sub   <= (tap == TAP_A1 || tap == TAP_A2);
          prod_valid <= 1'b1;
          acc        <= acc_next;
          tap        <= tap + 3'd1;
          if (tap == TAP_A2) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          // fold in the last product
          acc        <= acc_next;
          prod_valid <= 1'b0;
          state      <= ST_WB;
        end
        ST_WB: begin
          cur <= sec_y >>> sec_shift;
          if (sec_is_last) begin
            state <= ST_OUT;
          end else begin
            sec   <= sec + 1'b1;
            state <= ST_READ;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= cur;
            out_last  <= last;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/bqc_hist_mem.sv -----
// History memory of the biquad cascade: one row {x1,x2,y1,y2} per section.
// Depends on bqc_pkg. Registered read; rows never written read as zero.
module bqc_hist_mem (
  input  logic              clk,
  input  logic              rst,
  input  bqc_pkg::hist_port_t port,
  output bqc_pkg::hist_row_t  rdata
);
  import bqc_pkg::*;

  hist_row_t                mem [NUM_SECTIONS];
  logic [NUM_SECTIONS-1:0]  row_valid;
  hist_row_t                rd_row;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (port.wr_en) begin
      mem[port.addr] <= port.wdata;
    end
    if (port.rd_en) begin
      rd_row <= mem[port.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (port.wr_en) begin
        row_valid[port.addr] <= 1'b1;
      end
      if (port.rd_en) begin
        rd_valid <= row_valid[port.addr];
      end
    end
  end

  assign rdata = rd_valid ? rd_row : '0;

endmodule
